// ===== rtl/cnbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cnbm_pkg
// Shared constants, types and width helpers for the causal neighbourhood
// best-match block.
// ----------------------------------------------------------------------------
`default_nettype none

package cnbm_pkg;

  localparam int unsigned MaxWidthDef      = 64;
  localparam int unsigned MaxHeightDef     = 64;
  localparam int unsigned MaxHalfWindowDef = 4;

  localparam int unsigned CfgDataW = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned HalfCfgW = 3;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned CoordW   = 6;
  localparam int unsigned DistW    = 23;

  localparam int unsigned PixDistMax = 3 * 255 * 255;
  localparam int unsigned PixW       = $clog2(PixDistMax + 1);

  localparam logic [CfgDataW-1:0] WidthRst  = 7'd64;
  localparam logic [CfgDataW-1:0] HeightRst = 7'd64;
  localparam logic [HalfCfgW-1:0] HalfRst   = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSourceWidth  = 2'd0,
    CfgSourceHeight = 2'd1,
    CfgHalfWindow   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FuncLoad  = 1'b0,
    FuncQuery = 1'b1
  } func_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic zero;
  } issue_t;

  typedef struct packed {
    logic              found;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
    rgb_t              pixel;
    logic [DistW-1:0]  distance;
  } result_t;

  function automatic int unsigned qry_depth(input int unsigned max_half);
    return max_half * (2 * max_half + 1) + max_half;
  endfunction

  function automatic int unsigned sum_width(input int unsigned max_half);
    return $clog2(PixDistMax * qry_depth(max_half) + 1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cnbm_if.sv =====
// ----------------------------------------------------------------------------
// cnbm_if
// Valid/ready channels for pixel input and match results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cnbm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic                       first;
  logic                       last;
  logic [cnbm_pkg::ChanW-1:0] red;
  logic [cnbm_pkg::ChanW-1:0] green;
  logic [cnbm_pkg::ChanW-1:0] blue;

  modport source (output valid, func, first, last, red, green, blue, input ready);
  modport sink   (input valid, func, first, last, red, green, blue, output ready);
endinterface

interface cnbm_out_if;
  logic                        valid;
  logic                        ready;
  logic [cnbm_pkg::CoordW-1:0] best_column;
  logic [cnbm_pkg::CoordW-1:0] best_row;
  logic [cnbm_pkg::ChanW-1:0]  match_red;
  logic [cnbm_pkg::ChanW-1:0]  match_green;
  logic [cnbm_pkg::ChanW-1:0]  match_blue;
  logic [cnbm_pkg::DistW-1:0]  match_distance;
  logic                        found;

  modport source (output valid, best_column, best_row, match_red, match_green, match_blue,
                  match_distance, found, input ready);
  modport sink   (input valid, best_column, best_row, match_red, match_green, match_blue,
                  match_distance, found, output ready);
endinterface

`default_nettype wire

// ===== rtl/cnbm_store.sv =====
// ----------------------------------------------------------------------------
// cnbm_store
// Source image and query neighbourhood memories with their write position
// counters; registered read ports for the search.
// ----------------------------------------------------------------------------
`default_nettype none

module cnbm_store #(
  parameter  int unsigned MAX_WIDTH       = cnbm_pkg::MaxWidthDef,
  parameter  int unsigned MAX_HEIGHT      = cnbm_pkg::MaxHeightDef,
  parameter  int unsigned MAX_HALF_WINDOW = cnbm_pkg::MaxHalfWindowDef,
  localparam int unsigned SrcDepth        = MAX_WIDTH * MAX_HEIGHT,
  localparam int unsigned QryDepth        = cnbm_pkg::qry_depth(MAX_HALF_WINDOW),
  localparam int unsigned SrcAw           = $clog2(SrcDepth),
  localparam int unsigned QryAw           = $clog2(QryDepth)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic             wr_func_i,
  input  wire logic             wr_first_i,
  input  cnbm_pkg::rgb_t        wr_pixel_i,
  input  wire logic             src_rd_en_i,
  input  wire logic [SrcAw-1:0] src_rd_addr_i,
  input  wire logic             qry_rd_en_i,
  input  wire logic [QryAw-1:0] qry_rd_addr_i,
  output cnbm_pkg::rgb_t        src_rd_data_o,
  output cnbm_pkg::rgb_t        qry_rd_data_o
);

  localparam int unsigned QryPosW = $clog2(QryDepth + 1);

  cnbm_pkg::rgb_t src_mem [SrcDepth];
  cnbm_pkg::rgb_t qry_mem [QryDepth];

  logic [SrcAw-1:0]   load_pos_q, load_pos_d, load_addr;
  logic [QryPosW-1:0] qry_pos_q, qry_pos_d, qry_addr;
  logic               load_we, qry_we;
  cnbm_pkg::rgb_t     src_rd_q, qry_rd_q;

  always_comb begin
    load_addr  = wr_first_i ? '0 : load_pos_q;
    qry_addr   = wr_first_i ? '0 : qry_pos_q;
    load_we    = wr_en_i && (cnbm_pkg::func_e'(wr_func_i) == cnbm_pkg::FuncLoad);
    qry_we     = wr_en_i && (cnbm_pkg::func_e'(wr_func_i) == cnbm_pkg::FuncQuery)
                 && (32'(qry_addr) < QryDepth);
    load_pos_d = load_pos_q;
    qry_pos_d  = qry_pos_q;
    if (load_we) begin
      load_pos_d = (load_addr == SrcAw'(SrcDepth - 1)) ? '0 : load_addr + 1'b1;
    end
    if (wr_en_i && (cnbm_pkg::func_e'(wr_func_i) == cnbm_pkg::FuncQuery)) begin
      qry_pos_d = qry_we ? qry_addr + 1'b1 : qry_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
      qry_pos_q  <= '0;
    end else begin
      load_pos_q <= load_pos_d;
      qry_pos_q  <= qry_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      src_mem[load_addr] <= wr_pixel_i;
    end
    if (src_rd_en_i) begin
      src_rd_q <= src_mem[src_rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (qry_we) begin
      qry_mem[qry_addr[QryAw-1:0]] <= wr_pixel_i;
    end
    if (qry_rd_en_i) begin
      qry_rd_q <= qry_mem[qry_rd_addr_i];
    end
  end

  assign src_rd_data_o = src_rd_q;
  assign qry_rd_data_o = qry_rd_q;

endmodule

`default_nettype wire

// ===== rtl/cnbm_unit.sv =====
// ----------------------------------------------------------------------------
// cnbm_unit
// Shared distance unit: one pixel distance per cycle, accumulated per centre,
// with a running first-minimum over all centres.
// ----------------------------------------------------------------------------
`default_nettype none

module cnbm_unit #(
  parameter  int unsigned MAX_WIDTH       = cnbm_pkg::MaxWidthDef,
  parameter  int unsigned MAX_HEIGHT      = cnbm_pkg::MaxHeightDef,
  parameter  int unsigned MAX_HALF_WINDOW = cnbm_pkg::MaxHalfWindowDef,
  localparam int unsigned SrcAw           = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int unsigned XW              = $clog2(MAX_WIDTH),
  localparam int unsigned YW              = $clog2(MAX_HEIGHT),
  localparam int unsigned SumW            = cnbm_pkg::sum_width(MAX_HALF_WINDOW)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             clr_i,
  input  cnbm_pkg::issue_t      issue_i,
  input  wire logic [XW-1:0]    cx_i,
  input  wire logic [YW-1:0]    cy_i,
  input  wire logic [SrcAw-1:0] tl_i,
  input  cnbm_pkg::rgb_t        src_pix_i,
  input  cnbm_pkg::rgb_t        qry_pix_i,
  output logic                  busy_o,
  output logic [SrcAw-1:0]      best_tl_o,
  output logic [XW-1:0]         best_x_o,
  output logic [YW-1:0]         best_y_o,
  output logic [SumW-1:0]       best_dist_o
);

  localparam int unsigned PixW = cnbm_pkg::PixW;

  function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? a - b : b - a;
    return 16'(d) * 16'(d);
  endfunction

  cnbm_pkg::issue_t s1_q, s2_q;
  logic [XW-1:0]    s1_cx_q, s2_cx_q;
  logic [YW-1:0]    s1_cy_q, s2_cy_q;
  logic [SrcAw-1:0] s1_tl_q, s2_tl_q;
  logic [PixW-1:0]  pix_dist, s2_dist_q;
  logic [SumW-1:0]  acc_q, total, best_q;
  logic             have_q;
  logic [SrcAw-1:0] best_tl_q;
  logic [XW-1:0]    best_x_q;
  logic [YW-1:0]    best_y_q;

  always_comb begin
    pix_dist = PixW'(chan_sq(src_pix_i.red, qry_pix_i.red))
             + PixW'(chan_sq(src_pix_i.green, qry_pix_i.green))
             + PixW'(chan_sq(src_pix_i.blue, qry_pix_i.blue));
    total    = acc_q + SumW'(s2_dist_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      have_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      s1_q <= issue_i;
      s2_q <= s1_q;
      if (clr_i) begin
        have_q <= 1'b0;
        acc_q  <= '0;
      end else if (s2_q.valid) begin
        if (s2_q.last) begin
          acc_q <= '0;
          if (!have_q || (total < best_q)) begin
            have_q <= 1'b1;
          end
        end else begin
          acc_q <= total;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cx_q   <= cx_i;
    s1_cy_q   <= cy_i;
    s1_tl_q   <= tl_i;
    s2_cx_q   <= s1_cx_q;
    s2_cy_q   <= s1_cy_q;
    s2_tl_q   <= s1_tl_q;
    s2_dist_q <= s1_q.zero ? '0 : pix_dist;
    if (s2_q.valid && s2_q.last && (!have_q || (total < best_q))) begin
      best_q    <= total;
      best_tl_q <= s2_tl_q;
      best_x_q  <= s2_cx_q;
      best_y_q  <= s2_cy_q;
    end
  end

  assign busy_o      = s1_q.valid | s2_q.valid;
  assign best_tl_o   = best_tl_q;
  assign best_x_o    = best_x_q;
  assign best_y_o    = best_y_q;
  assign best_dist_o = best_q;

endmodule

`default_nettype wire

// ===== rtl/cnbm_seq.sv =====
// ----------------------------------------------------------------------------
// cnbm_seq
// Search sequencer: configuration registers, window and centre walk, address
// generation for the shared distance unit, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cnbm_seq #(
  parameter  int unsigned MAX_WIDTH       = cnbm_pkg::MaxWidthDef,
  parameter  int unsigned MAX_HEIGHT      = cnbm_pkg::MaxHeightDef,
  parameter  int unsigned MAX_HALF_WINDOW = cnbm_pkg::MaxHalfWindowDef,
  localparam int unsigned SrcAw           = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int unsigned QryAw           = $clog2(cnbm_pkg::qry_depth(MAX_HALF_WINDOW)),
  localparam int unsigned XW              = $clog2(MAX_WIDTH),
  localparam int unsigned YW              = $clog2(MAX_HEIGHT),
  localparam int unsigned SumW            = cnbm_pkg::sum_width(MAX_HALF_WINDOW)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cnbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [cnbm_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          start_i,
  output logic                               idle_o,
  output cnbm_pkg::issue_t                   issue_o,
  output logic [XW-1:0]                      cx_o,
  output logic [YW-1:0]                      cy_o,
  output logic [SrcAw-1:0]                   tl_o,
  output logic                               unit_clr_o,
  input  wire logic                          busy_i,
  input  wire logic [SrcAw-1:0]              best_tl_i,
  input  wire logic [XW-1:0]                 best_x_i,
  input  wire logic [YW-1:0]                 best_y_i,
  input  wire logic [SumW-1:0]               best_dist_i,
  output logic                               src_rd_en_o,
  output logic [SrcAw-1:0]                   src_rd_addr_o,
  output logic [QryAw-1:0]                   qry_rd_addr_o,
  input  cnbm_pkg::rgb_t                     src_rd_data_i,
  output cnbm_pkg::result_t                  res_o,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i
);

  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW    = $clog2(MAX_HALF_WINDOW + 1);
  localparam int unsigned SideW = $clog2(2 * MAX_HALF_WINDOW + 2);
  localparam int unsigned DistMax = (1 << cnbm_pkg::DistW) - 1;

  typedef enum logic [2:0] {
    StIdle, StSetup, StInit, StScan, StDrain, StCentre, StResult
  } state_e;

  state_e state_q, state_d;

  logic [cnbm_pkg::CfgDataW-1:0] sw_q, sh_q;
  logic [cnbm_pkg::HalfCfgW-1:0] hw_q;

  logic [WW-1:0]        w_eff;
  logic [HW-1:0]        h_eff;
  logic [RW-1:0]        r_eff;
  logic [SideW-1:0]     side_eff;
  logic [RW+WW-1:0]     rw_prod;
  logic [RW+SideW-1:0]  n_eff;

  logic [WW-1:0]    w_q;
  logic [RW-1:0]    r_q;
  logic [SideW-1:0] side_q, jend_q;
  logic [QryAw-1:0] nm1_q;
  logic [SrcAw-1:0] ctr_off_q;
  logic             fit_q;
  logic [XW-1:0]    xend_q;
  logic [YW-1:0]    yend_q;

  logic [XW-1:0]    cx_q, cx_d;
  logic [YW-1:0]    cy_q, cy_d;
  logic [SrcAw-1:0] tl_q, tl_d, row_q, row_d, addr_q, addr_d;
  logic [QryAw-1:0] qi_q, qi_d;
  logic [SideW-1:0] j_q, j_d;

  cnbm_pkg::result_t res_q, res_d;
  logic              res_valid_d, res_valid_q;
  logic              elem_last, zero_r;
  logic [31:0]       bx32, by32;

  always_comb begin
    w_eff    = (32'(sw_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(sw_q);
    h_eff    = (32'(sh_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(sh_q);
    r_eff    = (32'(hw_q) > MAX_HALF_WINDOW) ? RW'(MAX_HALF_WINDOW) : RW'(hw_q);
    side_eff = SideW'({r_eff, 1'b1});
    rw_prod  = (RW+WW)'(r_eff) * (RW+WW)'(w_eff) + (RW+WW)'(r_eff);
    n_eff    = (RW+SideW)'(r_eff) * (RW+SideW)'(side_eff) + (RW+SideW)'(r_eff);
  end

  always_comb begin
    zero_r     = (r_q == '0);
    elem_last  = zero_r || (qi_q == nm1_q);
    bx32       = 32'(best_x_i);
    by32       = 32'(best_y_i);
    state_d    = state_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    tl_d       = tl_q;
    row_d      = row_q;
    addr_d     = addr_q;
    qi_d       = qi_q;
    j_d        = j_q;
    res_d      = res_q;
    res_valid_d = res_valid_q && !res_ready_i;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StSetup;
        end
      end
      StSetup: begin
        state_d = StInit;
      end
      StInit: begin
        cx_d    = XW'(r_q);
        cy_d    = YW'(r_q);
        tl_d    = '0;
        row_d   = '0;
        addr_d  = '0;
        qi_d    = '0;
        j_d     = '0;
        state_d = fit_q ? StScan : StResult;
      end
      StScan: begin
        if (elem_last) begin
          qi_d = '0;
          j_d  = '0;
          if (cx_q == xend_q) begin
            if (cy_q == yend_q) begin
              state_d = StDrain;
            end
            cx_d = XW'(r_q);
            cy_d = cy_q + 1'b1;
            tl_d = tl_q + SrcAw'(side_q);
          end else begin
            cx_d = cx_q + 1'b1;
            tl_d = tl_q + 1'b1;
          end
          row_d  = tl_d;
          addr_d = tl_d;
        end else begin
          qi_d = qi_q + 1'b1;
          if (j_q == jend_q) begin
            j_d    = '0;
            row_d  = row_q + SrcAw'(w_q);
            addr_d = row_d;
          end else begin
            j_d    = j_q + 1'b1;
            addr_d = addr_q + 1'b1;
          end
        end
      end
      StDrain: begin
        if (!busy_i) begin
          state_d = StCentre;
        end
      end
      StCentre: begin
        state_d = StResult;
      end
      StResult: begin
        if (!res_valid_q || res_ready_i) begin
          res_d       = '0;
          res_valid_d = 1'b1;
          if (fit_q) begin
            res_d.found    = 1'b1;
            res_d.column   = bx32[cnbm_pkg::CoordW-1:0];
            res_d.row      = by32[cnbm_pkg::CoordW-1:0];
            res_d.pixel    = src_rd_data_i;
            res_d.distance = (32'(best_dist_i) > DistMax) ? cnbm_pkg::DistW'(DistMax)
                                                           : cnbm_pkg::DistW'(best_dist_i);
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_valid_q <= 1'b0;
      sw_q        <= cnbm_pkg::WidthRst;
      sh_q        <= cnbm_pkg::HeightRst;
      hw_q        <= cnbm_pkg::HalfRst;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        unique case (cnbm_pkg::cfg_idx_e'(cfg_idx_i))
          cnbm_pkg::CfgSourceWidth:  sw_q <= cfg_data_i;
          cnbm_pkg::CfgSourceHeight: sh_q <= cfg_data_i;
          cnbm_pkg::CfgHalfWindow:   hw_q <= cfg_data_i[cnbm_pkg::HalfCfgW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StSetup) begin
      w_q       <= w_eff;
      r_q       <= r_eff;
      side_q    <= side_eff;
      jend_q    <= SideW'({r_eff, 1'b0});
      nm1_q     <= QryAw'(n_eff - 1'b1);
      ctr_off_q <= SrcAw'(rw_prod);
      fit_q     <= (32'(w_eff) >= 32'(side_eff)) && (32'(h_eff) >= 32'(side_eff));
      xend_q    <= XW'(32'(w_eff) - 32'(r_eff) - 32'd1);
      yend_q    <= YW'(32'(h_eff) - 32'(r_eff) - 32'd1);
    end
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    tl_q   <= tl_d;
    row_q  <= row_d;
    addr_q <= addr_d;
    qi_q   <= qi_d;
    j_q    <= j_d;
    res_q  <= res_d;
  end

  always_comb begin
    issue_o.valid = (state_q == StScan);
    issue_o.last  = elem_last;
    issue_o.zero  = zero_r;
    src_rd_en_o   = (state_q == StScan) || (state_q == StCentre);
    src_rd_addr_o = (state_q == StCentre) ? best_tl_i + ctr_off_q : addr_q;
  end

  assign idle_o        = (state_q == StIdle);
  assign cx_o          = cx_q;
  assign cy_o          = cy_q;
  assign tl_o          = tl_q;
  assign unit_clr_o    = (state_q == StInit);
  assign qry_rd_addr_o = qi_q;
  assign res_o         = res_q;
  assign res_valid_o   = res_valid_q;

endmodule

`default_nettype wire

// ===== rtl/causal_neighbourhood_best_match.sv =====
// Load or non-final query pixel: the next transfer may follow at once.
// Final query pixel: starts the search over C = (w-2r)*(h-2r) candidate centres
// of N = 2r(r+1) neighbourhood pixels each; the shared distance unit
// takes one pixel pair per cycle. Input is not ready during the search.
// Reset clears positions and control, sets width/height/radius to 64/64/4;
// the stores are not cleared.
// ----------------------------------------------------------------------------
// causal_neighbourhood_best_match
// Loads a source image, takes a causal L-shaped query neighbourhood and finds
// the first source centre with the least sum of squared RGB differences.
// ----------------------------------------------------------------------------
`default_nettype none

module causal_neighbourhood_best_match #(
  parameter int unsigned MAX_WIDTH       = cnbm_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT      = cnbm_pkg::MaxHeightDef,
  parameter int unsigned MAX_HALF_WINDOW = cnbm_pkg::MaxHalfWindowDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cnbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [cnbm_pkg::CfgDataW-1:0] cfg_data_i,
  cnbm_in_if.sink                            in_i,
  cnbm_out_if.source                         out_o
);

  localparam int unsigned SrcAw = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned QryAw = $clog2(cnbm_pkg::qry_depth(MAX_HALF_WINDOW));
  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned SumW  = cnbm_pkg::sum_width(MAX_HALF_WINDOW);

  logic              idle, accept, start, unit_clr, busy, src_rd_en;
  cnbm_pkg::rgb_t    in_pixel, src_rd_data, qry_rd_data;
  cnbm_pkg::issue_t  issue;
  cnbm_pkg::result_t res;
  logic [XW-1:0]     cx, best_x;
  logic [YW-1:0]     cy, best_y;
  logic [SrcAw-1:0]  tl, best_tl, src_rd_addr;
  logic [QryAw-1:0]  qry_rd_addr;
  logic [SumW-1:0]   best_dist;

  assign accept   = in_i.valid & in_i.ready;
  assign start    = accept && (cnbm_pkg::func_e'(in_i.func) == cnbm_pkg::FuncQuery)
                    && in_i.last;
  assign in_pixel = '{red: in_i.red, green: in_i.green, blue: in_i.blue};
  assign in_i.ready = idle;

  cnbm_store #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (accept),
    .wr_func_i     (in_i.func),
    .wr_first_i    (in_i.first),
    .wr_pixel_i    (in_pixel),
    .src_rd_en_i   (src_rd_en),
    .src_rd_addr_i (src_rd_addr),
    .qry_rd_en_i   (issue.valid),
    .qry_rd_addr_i (qry_rd_addr),
    .src_rd_data_o (src_rd_data),
    .qry_rd_data_o (qry_rd_data)
  );

  cnbm_unit #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW)
  ) u_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (unit_clr),
    .issue_i     (issue),
    .cx_i        (cx),
    .cy_i        (cy),
    .tl_i        (tl),
    .src_pix_i   (src_rd_data),
    .qry_pix_i   (qry_rd_data),
    .busy_o      (busy),
    .best_tl_o   (best_tl),
    .best_x_o    (best_x),
    .best_y_o    (best_y),
    .best_dist_o (best_dist)
  );

  cnbm_seq #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .start_i       (start),
    .idle_o        (idle),
    .issue_o       (issue),
    .cx_o          (cx),
    .cy_o          (cy),
    .tl_o          (tl),
    .unit_clr_o    (unit_clr),
    .busy_i        (busy),
    .best_tl_i     (best_tl),
    .best_x_i      (best_x),
    .best_y_i      (best_y),
    .best_dist_i   (best_dist),
    .src_rd_en_o   (src_rd_en),
    .src_rd_addr_o (src_rd_addr),
    .qry_rd_addr_o (qry_rd_addr),
    .src_rd_data_i (src_rd_data),
    .res_o         (res),
    .res_valid_o   (out_o.valid),
    .res_ready_i   (out_o.ready)
  );

  assign out_o.best_column    = res.column;
  assign out_o.best_row       = res.row;
  assign out_o.match_red      = res.pixel.red;
  assign out_o.match_green    = res.pixel.green;
  assign out_o.match_blue     = res.pixel.blue;
  assign out_o.match_distance = res.distance;
  assign out_o.found          = res.found;

endmodule

`default_nettype wire

// ===== rtl/cnbm_checker.sv =====
// ----------------------------------------------------------------------------
// cnbm_checker
// Port-level checks on search start, result hold and result contents.
// ----------------------------------------------------------------------------
`default_nettype none

module cnbm_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        in_func_i,
  input wire logic                        in_last_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic                        out_found_i,
  input wire logic [cnbm_pkg::CoordW-1:0] out_column_i,
  input wire logic [cnbm_pkg::CoordW-1:0] out_row_i,
  input wire logic [cnbm_pkg::ChanW-1:0]  out_red_i,
  input wire logic [cnbm_pkg::ChanW-1:0]  out_green_i,
  input wire logic [cnbm_pkg::ChanW-1:0]  out_blue_i,
  input wire logic [cnbm_pkg::DistW-1:0]  out_dist_i
);

  logic in_xfer, query_end, load_xfer;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign query_end = in_xfer && (in_func_i == cnbm_pkg::FuncQuery) && in_last_i;
  assign load_xfer = in_xfer && (in_func_i == cnbm_pkg::FuncLoad);

  a_search_blocks_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni) query_end |=> !in_ready_i
  ) else $error("input ready right after final query pixel");

  a_load_keeps_ready: assert property (
    @(posedge clk_i) disable iff (!rst_ni) load_xfer |=> in_ready_i
  ) else $error("load transfer dropped ready");

  a_result_after_search: assert property (
    @(posedge clk_i) disable iff (!rst_ni) $rose(out_valid_i) |-> $past(!in_ready_i)
  ) else $error("result appeared without a search");

  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_valid_i && !out_ready_i |=> out_valid_i
  ) else $error("result dropped before transfer");

  a_not_found_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_valid_i && !out_found_i |->
      (out_dist_i == '0) && (out_column_i == '0) && (out_row_i == '0) &&
      (out_red_i == '0) && (out_green_i == '0) && (out_blue_i == '0)
  ) else $error("empty result carries nonzero fields");

endmodule

bind causal_neighbourhood_best_match cnbm_checker u_cnbm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_func_i    (in_i.func),
  .in_last_i    (in_i.last),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_found_i  (out_o.found),
  .out_column_i (out_o.best_column),
  .out_row_i    (out_o.best_row),
  .out_red_i    (out_o.match_red),
  .out_green_i  (out_o.match_green),
  .out_blue_i   (out_o.match_blue),
  .out_dist_i   (out_o.match_distance)
);

`default_nettype wire
